>>> rtl/assert_macros.svh
// Assertion macros shared by the table RTL.
// Depends on a clock named clk and a synchronous reset named rst in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising edge, switched off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked on every rising edge, reset included.
`define ASSERT_CLK_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_CLK_ALL(lbl, prop, msg)
`endif
`endif

>>> rtl/ati_pkg.sv
// Package for the ordered table block: sizes, request and status codes,
// and the command and status structs between controller and datapath. No dependencies.
package ati_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int DATA_WIDTH  = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int POS_W       = 6;
  localparam int POS2_W      = 5;
  localparam int VAL_W       = 32;
  localparam int MIDX_W      = 5;

  typedef enum logic [2:0] {
    REQ_READ   = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_DELETE = 3'd2,
    REQ_SWAP   = 3'd3,
    REQ_FIND   = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADPOS  = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // Commands from the controller, at most one active per cycle.
  typedef struct packed {
    logic load;
    logic check;
    logic scan;
    logic drain;
    logic put;
    logic sw_a;
    logic sw_b;
    logic sw_c;
    logic sw_d;
    logic respond;
  } ati_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    req_t kind;
    logic go;
    logic walk;
    logic at_end;
    logic hit;
  } ati_stat_t;

endpackage

>>> rtl/array_table_insert_delete_find_top.sv
// Top level of the ordered table block: ties the controller to the datapath.
// Depends on ati_pkg, ati_ctrl and ati_dp.
//
// The block keeps an ordered table of up to 32 signed words and a count of
// valid entries. An item is taken at a rising edge where start is high and
// busy is low; its single result is registered in the done state and then
// appears on status, data_out, match_index, found and entry_count, with
// done high for exactly one cycle. The receiver cannot stall, so capture
// the result whenever done is high. Busy drops in the same cycle done rises,
// so the next item may be issued while the result is on the ports. The table
// sits in a memory with one write and one read port, and shifts walk it one
// entry per cycle, so that port sets the time. A rejected request goes from
// the check state straight to done; a read scans its entry and drains;
// a swap steps through SW_A to SW_D; an insert or a delete scans the entries
// it moves and drains, then puts, or puts straight after the check when
// nothing moves; a find scans the valid entries, stopping early at a match.
// Table contents are not cleared by reset; the count is, and no request
// ever reads an entry beyond the count.
module array_table_insert_delete_find_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [2:0]                       req_type,
  input  logic [ati_pkg::POS_W-1:0]        position,
  input  logic [ati_pkg::POS2_W-1:0]       second_position,
  input  logic signed [ati_pkg::VAL_W-1:0] value,
  output logic                             done,
  output logic [1:0]                       status,
  output logic signed [ati_pkg::VAL_W-1:0] data_out,
  output logic [ati_pkg::MIDX_W-1:0]       match_index,
  output logic                             found,
  output logic [ati_pkg::CNT_W-1:0]        entry_count
);
  import ati_pkg::*;

  // Command and status buses between the two halves.
  ati_cmd_t  cmd;
  ati_stat_t stat;

  ati_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  ati_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .req_type        (req_type),
    .position        (position),
    .second_position (second_position),
    .value           (value),
    .done            (done),
    .status          (status),
    .data_out        (data_out),
    .match_index     (match_index),
    .found           (found),
    .entry_count     (entry_count)
  );

endmodule

>>> rtl/ati_ctrl.sv
// Controller state machine of the ordered table block.
// Depends on ati_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ati_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ati_pkg::ati_stat_t stat,
  output ati_pkg::ati_cmd_t  cmd
);
  import ati_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CHECK = 10'b0000000010,
    S_SCAN  = 10'b0000000100,
    S_DRAIN = 10'b0000001000,
    S_PUT   = 10'b0000010000,
    S_SW_A  = 10'b0000100000,
    S_SW_B  = 10'b0001000000,
    S_SW_C  = 10'b0010000000,
    S_SW_D  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (!stat.go) begin
          state_next = S_DONE;
        end else begin
          case (stat.kind)
            REQ_READ, REQ_FIND: state_next = S_SCAN;
            REQ_INSERT, REQ_DELETE: state_next = stat.walk ? S_SCAN : S_PUT;
            REQ_SWAP: state_next = S_SW_A;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.kind == REQ_FIND && stat.hit) begin
          state_next = S_DONE;
        end else if (stat.at_end) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.drain = 1'b1;
        if (stat.kind == REQ_INSERT || stat.kind == REQ_DELETE) begin
          state_next = S_PUT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_PUT: begin
        cmd.put    = 1'b1;
        state_next = S_DONE;
      end
      S_SW_A: begin
        cmd.sw_a   = 1'b1;
        state_next = S_SW_B;
      end
      S_SW_B: begin
        cmd.sw_b   = 1'b1;
        state_next = S_SW_C;
      end
      S_SW_C: begin
        cmd.sw_c   = 1'b1;
        state_next = S_SW_D;
      end
      S_SW_D: begin
        cmd.sw_d   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.respond = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `ASSERT_CLK(a_drain_follows_scan, (state == S_DRAIN) |-> ($past(state) == S_SCAN), "drain without a preceding scan")
  `ASSERT_CLK(a_put_kind, (state == S_PUT) |-> (stat.kind == REQ_INSERT || stat.kind == REQ_DELETE), "put step on a request that does not resize the table")

endmodule

>>> rtl/ati_dp.sv
// Datapath of the ordered table block: request registers, table memory,
// entry count, walk pointer and result registers. Depends on ati_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ati_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  ati_pkg::ati_cmd_t           cmd,
  output ati_pkg::ati_stat_t          stat,
  input  logic [2:0]                  req_type,
  input  logic [ati_pkg::POS_W-1:0]   position,
  input  logic [ati_pkg::POS2_W-1:0]  second_position,
  input  logic signed [ati_pkg::VAL_W-1:0] value,
  output logic                        done,
  output logic [1:0]                  status,
  output logic signed [ati_pkg::VAL_W-1:0] data_out,
  output logic [ati_pkg::MIDX_W-1:0]  match_index,
  output logic                        found,
  output logic [ati_pkg::CNT_W-1:0]   entry_count
);
  import ati_pkg::*;

  logic [DATA_WIDTH-1:0] mem [TABLE_DEPTH];

  req_t                  kind;
  logic [POS_W-1:0]      pos;
  logic [POS2_W-1:0]     pos2;
  logic [DATA_WIDTH-1:0] word;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      ptr;
  logic [IDX_W-1:0]      rd_idx;
  logic                  rvalid;
  logic [DATA_WIDTH-1:0] rdata;
  logic [DATA_WIDTH-1:0] tmp;
  status_t               res_stat;
  logic [DATA_WIDTH-1:0] dout;
  logic [IDX_W-1:0]      midx;
  logic                  hit;

  status_t               chk_code;
  logic [CNT_W-1:0]      ptr_start;
  logic [CNT_W-1:0]      end_ptr;
  logic                  rd_en;
  logic [IDX_W-1:0]      raddr;
  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic                  resize;
  logic                  hit_now;

  // Bounds checks against the current count, a full check for inserts, and a find's starting status.
  always_comb begin
    case (kind)
      REQ_READ, REQ_DELETE: chk_code = (CNT_W'(pos) < count) ? ST_OK : ST_BADPOS;
      REQ_INSERT: begin
        if (CNT_W'(pos) > count) begin
          chk_code = ST_BADPOS;
        end else if (count == CNT_W'(TABLE_DEPTH)) begin
          chk_code = ST_FULL;
        end else begin
          chk_code = ST_OK;
        end
      end
      REQ_SWAP: chk_code = ((CNT_W'(pos) < count) && (CNT_W'(pos2) < count)) ? ST_OK : ST_BADPOS;
      REQ_FIND: chk_code = ST_MISSING;
      default:  chk_code = ST_BADPOS;
    endcase
  end

  always_comb begin
    case (kind)
      REQ_INSERT: ptr_start = count - CNT_W'(1);
      REQ_DELETE: ptr_start = CNT_W'(pos) + CNT_W'(1);
      REQ_FIND:   ptr_start = '0;
      default:    ptr_start = CNT_W'(pos);
    endcase
    if (kind == REQ_INSERT || kind == REQ_READ) begin
      end_ptr = CNT_W'(pos);
    end else begin
      end_ptr = count - CNT_W'(1);
    end
  end

  assign resize  = (kind == REQ_INSERT) || (kind == REQ_DELETE);
  assign hit_now = rvalid && (rdata == word);

  assign stat.kind   = kind;
  assign stat.go     = (kind == REQ_FIND) ? (count != '0) : (chk_code == ST_OK);
  assign stat.walk   = (kind == REQ_INSERT) ? (CNT_W'(pos) < count)
                                            : ((CNT_W'(pos) + CNT_W'(1)) < count);
  assign stat.at_end = (ptr == end_ptr);
  assign stat.hit    = hit_now;

  // Memory port selection.
  assign rd_en = cmd.scan || cmd.sw_a || cmd.sw_b;
  assign raddr = cmd.sw_b ? pos2 : ptr[IDX_W-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    if (cmd.sw_c) begin
      we    = 1'b1;
      waddr = pos[IDX_W-1:0];
    end else if (cmd.sw_d) begin
      we    = 1'b1;
      waddr = pos2;
      wdata = tmp;
    end else if (cmd.put) begin
      we    = (kind == REQ_INSERT);
      waddr = pos[IDX_W-1:0];
      wdata = word;
    end else if ((cmd.scan && rvalid) || cmd.drain) begin
      we    = resize;
      waddr = (kind == REQ_INSERT) ? (rd_idx + IDX_W'(1)) : (rd_idx - IDX_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= req_t'(req_type);
      pos  <= position;
      pos2 <= second_position;
      word <= DATA_WIDTH'(value);
      dout <= '0;
      midx <= '0;
      hit  <= 1'b0;
    end
    if (cmd.check) begin
      res_stat <= chk_code;
      ptr      <= ptr_start;
    end
    if (cmd.scan) begin
      rd_idx <= ptr[IDX_W-1:0];
      ptr    <= (kind == REQ_INSERT) ? (ptr - CNT_W'(1)) : (ptr + CNT_W'(1));
    end
    if ((cmd.scan || cmd.drain) && kind == REQ_FIND && hit_now && !hit) begin
      res_stat <= ST_OK;
      hit      <= 1'b1;
      midx     <= rd_idx;
    end
    if (cmd.drain && kind == REQ_READ) begin
      dout <= rdata;
    end
    if (cmd.sw_b) begin
      tmp <= rdata;
    end
    if (cmd.respond) begin
      status      <= res_stat;
      data_out    <= VAL_W'($signed(dout));
      match_index <= MIDX_W'(midx);
      found       <= hit;
      entry_count <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      rvalid <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= cmd.respond;
      if (cmd.check) begin
        rvalid <= 1'b0;
      end else if (cmd.scan) begin
        rvalid <= 1'b1;
      end
      if (cmd.put) begin
        count <= (kind == REQ_INSERT) ? (count + CNT_W'(1)) : (count - CNT_W'(1));
      end
    end
  end

  `ASSERT_CLK(a_count_range, count <= CNT_W'(TABLE_DEPTH), "entry count beyond table depth")
  `ASSERT_CLK(a_no_rw_clash, (we && rd_en) |-> (waddr != raddr), "shift writes the entry being read")

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the ordered table block: inserts, deletes, reads, swaps and finds.
// Depends on ati_pkg and array_table_insert_delete_find_top. It keeps its own table in step
// with every accepted item and checks each strobed result against it.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ati_pkg::*;

  // Request codes above REQ_FIND are not defined by the block and must be rejected.
  localparam logic [2:0] REQ_UNKNOWN_FIRST = 3'd5;
  localparam logic [2:0] REQ_UNKNOWN_LAST  = 3'd7;
  localparam int MAX_PRINTED = 40;

  // One result as the block should report it.
  typedef struct {
    status_t                 st;
    logic signed [VAL_W-1:0] data;
    logic [MIDX_W-1:0]       midx;
    logic                    hit;
    logic [CNT_W-1:0]        cnt;
  } table_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [2:0]              req_type = '0;
  logic [POS_W-1:0]        position = '0;
  logic [POS2_W-1:0]       second_position = '0;
  logic signed [VAL_W-1:0] value = '0;
  logic                    done;
  logic [1:0]              status;
  logic signed [VAL_W-1:0] data_out;
  logic [MIDX_W-1:0]       match_index;
  logic                    found;
  logic [CNT_W-1:0]        entry_count;

  array_table_insert_delete_find_top DUT (
    .clk, .rst, .start, .busy, .req_type, .position, .second_position, .value,
    .done, .status, .data_out, .match_index, .found, .entry_count
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The testbench's own copy of the table. Entries at and above shadow_count are
  // never looked at, which mirrors the block never reading unwritten memory.
  logic [DATA_WIDTH-1:0] shadow_table [TABLE_DEPTH];
  int                    shadow_count = 0;

  // Results still owed by the block, oldest first.
  table_result_t awaited_results [$];

  int mismatches = 0;
  int items_sent = 0;
  int results_checked = 0;
  int full_rejects = 0;
  int finds_hit = 0;
  int status_seen [4] = '{default: 0};

  // Applies one request to the shadow table and returns the result it must produce.
  function automatic table_result_t apply_table_request(logic [2:0] kind, logic [POS_W-1:0] pos,
                                                        logic [POS2_W-1:0] pos2,
                                                        logic signed [VAL_W-1:0] val);
    table_result_t         r;
    logic [DATA_WIDTH-1:0] tmp;
    r.st   = ST_OK;
    r.data = '0;
    r.midx = '0;
    r.hit  = 1'b0;
    case (kind)
      REQ_READ: begin
        if (pos < shadow_count) r.data = shadow_table[pos[IDX_W-1:0]];
        else r.st = ST_BADPOS;
      end
      REQ_INSERT: begin
        if (pos > shadow_count) begin
          r.st = ST_BADPOS;
        end else if (shadow_count >= TABLE_DEPTH) begin
          r.st = ST_FULL;
        end else begin
          // Everything from the insert point upward moves one slot toward the end.
          for (int i = shadow_count; i > pos; i--) shadow_table[i] = shadow_table[i-1];
          shadow_table[pos[IDX_W-1:0]] = val;
          shadow_count++;
        end
      end
      REQ_DELETE: begin
        if (pos < shadow_count) begin
          for (int i = pos; i + 1 < shadow_count; i++) shadow_table[i] = shadow_table[i+1];
          shadow_count--;
        end else begin
          r.st = ST_BADPOS;
        end
      end
      REQ_SWAP: begin
        if (pos < shadow_count && pos2 < shadow_count) begin
          tmp = shadow_table[pos[IDX_W-1:0]];
          shadow_table[pos[IDX_W-1:0]] = shadow_table[pos2];
          shadow_table[pos2] = tmp;
        end else begin
          r.st = ST_BADPOS;
        end
      end
      REQ_FIND: begin
        // Only valid entries are searched, and the lowest index wins.
        r.st = ST_MISSING;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_table[i] == val) begin
            r.st   = ST_OK;
            r.hit  = 1'b1;
            r.midx = MIDX_W'(i);
            break;
          end
        end
      end
      default: r.st = ST_BADPOS;
    endcase
    r.cnt = CNT_W'(shadow_count);
    return r;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("[%0t] MISMATCH %s", $realtime, what);
  endtask

  // Presents one item and holds it until the block takes it. Start is left high, so
  // the caller either presents the next item in the same step or lowers start.
  task automatic send_item(logic [2:0] kind, logic [POS_W-1:0] pos, logic [POS2_W-1:0] pos2,
                           logic signed [VAL_W-1:0] val);
    start           <= 1'b1;
    req_type        <= kind;
    position        <= pos;
    second_position <= pos2;
    value           <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    awaited_results.push_back(apply_table_request(kind, pos, pos2, val));
    items_sent++;
  endtask

  task automatic hold_off(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Random sender gaps, mostly short so they land on every step of a request's
  // walk, now and then long enough to cover a whole worst-case request.
  task automatic maybe_gap(int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      if ($urandom_range(0, 9) == 0) hold_off($urandom_range(10, 40));
      else hold_off($urandom_range(1, 6));
    end
  endtask

  // Small values repeat often, which gives finds several candidates to choose between.
  function automatic logic signed [VAL_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(VAL_W-1){1'b0}}};
      1:       return {1'b0, {(VAL_W-1){1'b1}}};
      2, 3, 4: return $signed(VAL_W'($urandom_range(0, 7))) - 3;
      default: return $urandom;
    endcase
  endfunction

  // Random traffic. Most positions fall inside the current table so the shifting
  // paths get exercised; a tenth are drawn over the whole port range.
  task automatic run_random(int n, int ins_pct, int del_pct, int idle_pct);
    logic [2:0]              kind;
    logic [POS_W-1:0]        pos;
    logic [POS2_W-1:0]       pos2;
    logic signed [VAL_W-1:0] val;
    int                      r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < ins_pct) kind = REQ_INSERT;
      else if (r < ins_pct + del_pct) kind = REQ_DELETE;
      else if ($urandom_range(0, 29) == 0)
        kind = 3'($urandom_range(REQ_UNKNOWN_FIRST, REQ_UNKNOWN_LAST));
      else begin
        case ($urandom_range(0, 2))
          0:       kind = REQ_READ;
          1:       kind = REQ_SWAP;
          default: kind = REQ_FIND;
        endcase
      end
      if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, 63));
      else if (kind == REQ_INSERT) pos = POS_W'($urandom_range(0, shadow_count));
      else pos = shadow_count > 0 ? POS_W'($urandom_range(0, shadow_count - 1)) : '0;
      if ($urandom_range(0, 9) == 0 || shadow_count == 0)
        pos2 = POS2_W'($urandom_range(0, 31));
      else pos2 = POS2_W'($urandom_range(0, shadow_count - 1));
      val = pick_word();
      if (kind == REQ_FIND && shadow_count > 0 && $urandom_range(0, 9) < 7)
        val = shadow_table[$urandom_range(0, shadow_count - 1)];
      maybe_gap(idle_pct);
      send_item(kind, pos, pos2, val);
    end
  endtask

  // Every request on an empty table: all must be rejected except the append at zero
  // that comes later, and an insert past the end is refused.
  task automatic test_empty_table();
    send_item(REQ_READ, 0, 0, 0);
    send_item(REQ_DELETE, 0, 0, 0);
    send_item(REQ_SWAP, 0, 0, 0);
    send_item(REQ_FIND, 0, 0, 0);
    send_item(REQ_INSERT, 1, 0, 5);
    for (int k = REQ_UNKNOWN_FIRST; k <= REQ_UNKNOWN_LAST; k++)
      send_item(3'(k), POS_W'($urandom_range(0, 63)), POS2_W'($urandom_range(0, 31)),
                $urandom);
  endtask

  // Extreme words at the front, the end and the middle, then reads, finds, swaps
  // and deletes around them, including positions far past the end.
  task automatic test_edge_requests();
    send_item(REQ_INSERT, 0, 0, {1'b1, {(VAL_W-1){1'b0}}});
    send_item(REQ_INSERT, 1, 0, {1'b0, {(VAL_W-1){1'b1}}});
    send_item(REQ_INSERT, 1, 0, -1);
    send_item(REQ_INSERT, 0, 0, 0);
    send_item(REQ_READ, 3, 0, 0);
    send_item(REQ_READ, 4, 0, 0);
    send_item(REQ_READ, 63, 0, 0);
    send_item(REQ_FIND, 0, 0, {1'b0, {(VAL_W-1){1'b1}}});
    send_item(REQ_FIND, 0, 0, {1'b1, {(VAL_W-1){1'b0}}});
    send_item(REQ_FIND, 0, 0, 12345);
    send_item(REQ_SWAP, 0, 3, 0);
    send_item(REQ_SWAP, 2, 2, 0);
    send_item(REQ_SWAP, 1, 31, 0);
    send_item(REQ_DELETE, 1, 0, 0);
    send_item(REQ_DELETE, 63, 0, 0);
    send_item(REQ_INSERT, 63, 0, 7);
    send_item(REQ_DELETE, POS_W'(shadow_count - 1), 0, 0);
  endtask

  task automatic test_fill_to_full(int n, int idle_pct);
    run_random(n, 80, 5, idle_pct);
  endtask

  task automatic test_mixed_traffic(int n, int idle_pct);
    run_random(n, 25, 25, idle_pct);
  endtask

  task automatic test_drain(int n, int idle_pct);
    run_random(n, 5, 80, idle_pct);
  endtask

  // The sender stops until every owed result is back, then resumes on a quiet block.
  task automatic test_quiet_pause();
    hold_off(1);
    while (awaited_results.size() != 0) @(posedge clk);
    send_item(REQ_FIND, 0, 0, shadow_count > 0 ? shadow_table[0] : 0);
    send_item(REQ_READ, 0, 0, 0);
  endtask

  // Result checker. The receiver cannot stall, so every strobe is taken at the edge
  // that closes it and compared against the oldest owed result.
  always @(posedge clk) begin
    table_result_t want;
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result strobed with no request outstanding");
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        status_seen[want.st]++;
        if (want.st == ST_FULL) full_rejects++;
        if (want.hit) finds_hit++;
        if (status !== want.st)
          report_mismatch($sformatf("status got %0d want %0d", status, want.st));
        if (data_out !== want.data)
          report_mismatch($sformatf("data_out got %0d want %0d", data_out, want.data));
        if (match_index !== want.midx)
          report_mismatch($sformatf("match_index got %0d want %0d", match_index, want.midx));
        if (found !== want.hit)
          report_mismatch($sformatf("found got %0b want %0b", found, want.hit));
        if (entry_count !== want.cnt)
          report_mismatch($sformatf("entry_count got %0d want %0d", entry_count, want.cnt));
      end
    end
  end

  initial begin
    int drain_cycles;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_edge_requests();

    // No sender gaps.
    test_fill_to_full(90, 0);
    test_mixed_traffic(120, 0);
    test_drain(50, 0);

    // Sender idle most of the time.
    test_fill_to_full(80, 78);
    test_mixed_traffic(100, 78);
    test_quiet_pause();
    test_drain(50, 78);

    // Sender idle about a third of the time.
    test_fill_to_full(80, 32);
    test_mixed_traffic(150, 32);
    test_drain(60, 32);
    test_mixed_traffic(45, 0);

    // Let the last results come back, then a margin past the longest request.
    hold_off(1);
    drain_cycles = 0;
    while (awaited_results.size() != 0 && drain_cycles < 2000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (40) @(posedge clk);
    while (awaited_results.size() != 0) begin
      void'(awaited_results.pop_front());
      report_mismatch("request never produced a result");
    end

    $display("Covered %0d requests and %0d results: ok %0d, bad position %0d, full %0d, miss %0d.",
             items_sent, results_checked, status_seen[ST_OK], status_seen[ST_BADPOS],
             status_seen[ST_FULL], status_seen[ST_MISSING]);
    $display("Full-table rejects %0d, successful finds %0d, field mismatches %0d.",
             full_rejects, finds_hit, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Backstop: the slowest legal run is well under a millisecond.
  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding.", awaited_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> array_table_insert_delete_find_top.f
+incdir+rtl
rtl/ati_pkg.sv
rtl/ati_ctrl.sv
rtl/ati_dp.sv
rtl/array_table_insert_delete_find_top.sv
tb/sv/testbench.sv
